@@ hw/rtl/nta_pkg.sv @@
// ----------------------------------------------------------------------------
// nta_pkg: shared types and constants for the number to ASCII converter
// Digit cell count, format codes, cell operations, controller states and
// the digit glyph lookup.
// ----------------------------------------------------------------------------
package nta_pkg;

    localparam int NUM_CELLS  = 10;   // enough BCD digits for a 32-bit value
    localparam int VALUE_W    = 32;
    localparam int DIGIT_W    = 4;
    localparam int CHAR_W     = 7;
    localparam int CONV_STEPS = VALUE_W / DIGIT_W;  // bits enter DIGIT_W per cycle
    localparam int CNT_W      = $clog2(NUM_CELLS + 1);
    localparam int STEP_W     = $clog2(CONV_STEPS);

    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_HEX8  = 2'd0;
    localparam cmd_t CMD_HEX16 = 2'd1;
    localparam cmd_t CMD_HEX32 = 2'd2;
    localparam cmd_t CMD_DEC   = 2'd3;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD,
        OP_CONV,
        OP_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } state_t;

    function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ch;
        if (d < 4'd10) begin
            ch = 7'h30 + {3'b000, d};
        end else begin
            ch = 7'h37 + {3'b000, d};
        end
        return ch;
    endfunction

endpackage

@@ hw/rtl/number_to_ascii_hex_decimal.sv @@
// ----------------------------------------------------------------------------
// number_to_ascii_hex_decimal: binary to ASCII hex or decimal characters
// Accepts a format and a 32-bit value, streams out the ASCII digits most
// significant first, with tlast on the final character.
// ----------------------------------------------------------------------------
// One item is taken at a time. A hex item loads its nibbles into a chain of
// ten digit cells; a decimal item is converted in the same chain by shifting
// the value in four bits per cycle. Digits then move up the chain one cell
// per cycle, holding while the output is stalled: leading positions are
// dropped from the top cell, then each character is sent from it.
module number_to_ascii_hex_decimal (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] character, [7] zero pad
    output logic        m_tlast
);

    localparam int N = nta_pkg::NUM_CELLS;
    localparam int DW = nta_pkg::DIGIT_W;
    localparam int VW = nta_pkg::VALUE_W;

    nta_pkg::state_t                   state_reg, state_next;
    logic [VW-1:0]                     value_reg, value_next;
    logic [nta_pkg::STEP_W-1:0]        step_reg, step_next;
    logic [nta_pkg::CNT_W-1:0]         remain_reg, remain_next;
    logic [nta_pkg::CNT_W-1:0]         target_reg, target_next;
    logic                              hex_reg, hex_next;
    logic                              m_tvalid_reg, m_tvalid_next;
    logic [nta_pkg::CHAR_W-1:0]        char_reg, char_next;
    logic                              last_reg, last_next;

    nta_pkg::cell_ctrl_t               cell_ctrl;
    logic [DW-1:0]                     cell_load [N];
    logic [DW-1:0]                     cell_in_bits [N];
    logic [DW-1:0]                     cell_in_digit [N];
    logic [DW-1:0]                     cell_out_bits [N];
    logic [DW-1:0]                     cell_digit [N];

    logic                              accept;
    logic                              out_free;
    logic [DW-1:0]                     top_digit;

    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign top_digit = cell_digit[N-1];

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_cell
            if (k == 0) begin : g_first
                assign cell_in_bits[k]  = value_reg[VW-1 -: DW];
                assign cell_in_digit[k] = '0;
            end else begin : g_rest
                assign cell_in_bits[k]  = cell_out_bits[k-1];
                assign cell_in_digit[k] = cell_digit[k-1];
            end
            // hex nibbles sit in the low cells; decimal starts from all zeros
            if (k < VW / DW) begin : g_nib
                assign cell_load[k] = (s_tuser == nta_pkg::CMD_DEC) ? '0
                                                                    : s_tdata[k*DW +: DW];
            end else begin : g_zero
                assign cell_load[k] = '0;
            end
            nta_cell u_cell (
                .aclk       (aclk),
                .ctrl       (cell_ctrl),
                .load_digit (cell_load[k]),
                .in_bits    (cell_in_bits[k]),
                .in_digit   (cell_in_digit[k]),
                .out_bits   (cell_out_bits[k]),
                .digit      (cell_digit[k])
            );
        end
    endgenerate

    always_comb begin
        state_next    = state_reg;
        value_next    = value_reg;
        step_next     = step_reg;
        remain_next   = remain_reg;
        target_next   = target_reg;
        hex_next      = hex_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        char_next     = char_reg;
        last_next     = last_reg;
        cell_ctrl.op  = nta_pkg::OP_HOLD;
        s_tready      = 1'b0;

        case (state_reg)
            nta_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (accept) begin
                    cell_ctrl.op = nta_pkg::OP_LOAD;
                    value_next   = s_tdata;
                    step_next    = '0;
                    remain_next  = nta_pkg::CNT_W'(N);
                    hex_next     = (s_tuser != nta_pkg::CMD_DEC);
                    case (s_tuser)
                        nta_pkg::CMD_HEX8:  target_next = nta_pkg::CNT_W'(2);
                        nta_pkg::CMD_HEX16: target_next = nta_pkg::CNT_W'(4);
                        nta_pkg::CMD_HEX32: target_next = nta_pkg::CNT_W'(8);
                        default:            target_next = nta_pkg::CNT_W'(1);
                    endcase
                    state_next = (s_tuser == nta_pkg::CMD_DEC) ? nta_pkg::ST_CONV
                                                               : nta_pkg::ST_SKIP;
                end
            end
            nta_pkg::ST_CONV: begin
                cell_ctrl.op = nta_pkg::OP_CONV;
                value_next   = value_reg << DW;
                step_next    = step_reg + 1'b1;
                if (step_reg == nta_pkg::STEP_W'(nta_pkg::CONV_STEPS - 1)) begin
                    state_next = nta_pkg::ST_SKIP;
                end
            end
            nta_pkg::ST_SKIP: begin
                // hex drops a fixed number of positions; decimal drops leading zeros
                if (remain_reg != target_reg && (hex_reg || top_digit == '0)) begin
                    cell_ctrl.op = nta_pkg::OP_SHIFT;
                    remain_next  = remain_reg - 1'b1;
                end else begin
                    state_next = nta_pkg::ST_EMIT;
                end
            end
            nta_pkg::ST_EMIT: begin
                if (out_free) begin
                    cell_ctrl.op  = nta_pkg::OP_SHIFT;
                    m_tvalid_next = 1'b1;
                    char_next     = nta_pkg::digit_glyph(top_digit);
                    last_next     = (remain_reg == nta_pkg::CNT_W'(1));
                    remain_next   = remain_reg - 1'b1;
                    if (remain_reg == nta_pkg::CNT_W'(1)) begin
                        state_next = nta_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = nta_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= nta_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg  <= value_next;
        step_reg   <= step_next;
        remain_reg <= remain_next;
        target_reg <= target_next;
        hex_reg    <= hex_next;
        char_reg   <= char_next;
        last_reg   <= last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, char_reg};
    assign m_tlast  = last_reg;

endmodule

@@ hw/rtl/nta_cell.sv @@
// ----------------------------------------------------------------------------
// nta_cell: one digit cell of the conversion chain
// Holds a 4-bit digit. In convert mode it runs four shift-and-add-3 steps,
// taking bits from the lower neighbor and passing its overflow bits up.
// In shift mode it takes the lower neighbor's digit; in load mode, load_digit.
// ----------------------------------------------------------------------------
module nta_cell (
    input  logic                             aclk,
    input  nta_pkg::cell_ctrl_t              ctrl,
    input  logic [nta_pkg::DIGIT_W-1:0]      load_digit,
    input  logic [nta_pkg::DIGIT_W-1:0]      in_bits,    // bit 3 enters first
    input  logic [nta_pkg::DIGIT_W-1:0]      in_digit,
    output logic [nta_pkg::DIGIT_W-1:0]      out_bits,   // bit 3 leaves first
    output logic [nta_pkg::DIGIT_W-1:0]      digit
);

    logic [nta_pkg::DIGIT_W-1:0] digit_reg;
    logic [nta_pkg::DIGIT_W-1:0] digit_next;
    logic [nta_pkg::DIGIT_W-1:0] conv_digit;

    // double dabble: correct, then shift one bit in, per step
    always_comb begin
        logic [nta_pkg::DIGIT_W-1:0] d;
        d = digit_reg;
        out_bits = '0;
        for (int j = nta_pkg::DIGIT_W - 1; j >= 0; j--) begin
            if (d >= 4'd5) begin
                d = d + 4'd3;
            end
            out_bits[j] = d[nta_pkg::DIGIT_W-1];
            d = {d[nta_pkg::DIGIT_W-2:0], in_bits[j]};
        end
        conv_digit = d;
    end

    always_comb begin
        case (ctrl.op)
            nta_pkg::OP_HOLD:  digit_next = digit_reg;
            nta_pkg::OP_LOAD:  digit_next = load_digit;
            nta_pkg::OP_CONV:  digit_next = conv_digit;
            nta_pkg::OP_SHIFT: digit_next = in_digit;
            default:           digit_next = digit_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        digit_reg <= digit_next;
    end

    assign digit = digit_reg;

endmodule

@@ bench/number_to_ascii_hex_decimal_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// number_to_ascii_hex_decimal_tb: self-checking bench for the ASCII converter
// Sends format/value items over the input stream and predicts every output
// character, checking the glyph, the zero pad bit and tlast in order, with
// random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module number_to_ascii_hex_decimal_tb;

    localparam int STALL_LIMIT = 2000;   // cycles without any handshake
    localparam int TAIL_CYCLES = 40;
    localparam int RANDOM_ITEMS = 260;

    typedef struct {
        nta_pkg::cmd_t fmt;
        logic [31:0]   value;
        bit            drain;   // hold this item back until all characters are out
    } number_t;

    typedef struct {
        logic [6:0] ch;
        logic       last;
    } glyph_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // [31:0] value
    logic [1:0]  s_tuser = nta_pkg::CMD_HEX8;   // [1:0] cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // [6:0] character, [7] zero pad
    logic        m_tlast;

    number_t numbers_to_send[$];
    glyph_t  chars_due[$];
    int      mismatches = 0;
    int      numbers_taken = 0;
    int      stall_cycles = 0;
    bit      item_taken = 1'b0;
    bit      calm;

    number_to_ascii_hex_decimal dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // both sides run flat out for a stretch in the middle of the random part
    assign calm = (numbers_taken >= 120) && (numbers_taken < 180);

    function automatic logic [6:0] glyph_of(input logic [3:0] d);
        logic [7:0] code;
        code = (d < 4'd10) ? ("0" + d) : ("A" + (d - 4'd10));
        return code[6:0];
    endfunction

    // expected characters for one number, most significant first
    task automatic render_number(input nta_pkg::cmd_t fmt, input logic [31:0] value);
        logic [6:0]  rev [10];
        logic [31:0] v;
        int          n;
        int          ndig;
        glyph_t      g;
        v = value;
        n = 0;
        if (fmt != nta_pkg::CMD_DEC) begin
            ndig = 2 << fmt;
            for (int i = ndig - 1; i >= 0; i--) begin
                g.ch = glyph_of(v[4*i +: 4]);
                g.last = (i == 0);
                chars_due.push_back(g);
            end
        end else begin
            do begin
                rev[n] = glyph_of(4'(v % 10));
                v = v / 10;
                n++;
            end while (v != 0);
            for (int i = n - 1; i >= 0; i--) begin
                g.ch = rev[i];
                g.last = (i == 0);
                chars_due.push_back(g);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < 40)
            $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic add_number(input nta_pkg::cmd_t fmt, input logic [31:0] value,
                              input bit drain);
        number_t n;
        n.fmt = fmt;
        n.value = value;
        n.drain = drain;
        numbers_to_send.push_back(n);
    endtask

    // driver: a held item stays put until it is taken
    always @(negedge aclk) begin
        number_t n;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            if (!s_tvalid || item_taken) begin
                if (numbers_to_send.size() > 0
                        && !(numbers_to_send[0].drain && chars_due.size() > 0)
                        && (calm || $urandom_range(99) >= 36)) begin
                    n = numbers_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= n.value;
                    s_tuser <= n.fmt;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= calm || ($urandom_range(99) >= 36);
        end
    end

    // monitor: predict on input accept, check on output accept
    always @(posedge aclk) begin
        glyph_t g;
        item_taken = 1'b0;
        if (aresetn) begin
            item_taken = s_tvalid && s_tready;
            if (item_taken) begin
                render_number(nta_pkg::cmd_t'(s_tuser), s_tdata);
                numbers_taken++;
            end
            if (m_tvalid && m_tready) begin
                if (chars_due.size() == 0) begin
                    report_mismatch("unexpected character", 32'(m_tdata), '0);
                end else begin
                    g = chars_due.pop_front();
                    if (m_tdata !== {1'b0, g.ch})
                        report_mismatch("character", 32'(m_tdata), 32'({1'b0, g.ch}));
                    if (m_tlast !== g.last)
                        report_mismatch("tlast", 32'(m_tlast), 32'(g.last));
                end
            end
            stall_cycles = (item_taken || (m_tvalid && m_tready)) ? 0 : stall_cycles + 1;
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge aclk);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        logic [31:0] v;
        logic [31:0] pow10;
        // hex widths: extremes, leading zeros, ignored upper bits
        add_number(nta_pkg::CMD_HEX8, 32'h0000_0000, 1'b0);
        add_number(nta_pkg::CMD_HEX8, 32'hFFFF_FFFF, 1'b0);
        add_number(nta_pkg::CMD_HEX8, 32'h1234_50A5, 1'b0);
        add_number(nta_pkg::CMD_HEX16, 32'hFFFF_0000, 1'b0);
        add_number(nta_pkg::CMD_HEX16, 32'h0000_FFFF, 1'b0);
        add_number(nta_pkg::CMD_HEX16, 32'h0000_0C3B, 1'b0);
        add_number(nta_pkg::CMD_HEX32, 32'h0000_0000, 1'b0);
        add_number(nta_pkg::CMD_HEX32, 32'hFFFF_FFFF, 1'b0);
        add_number(nta_pkg::CMD_HEX32, 32'h89AB_CDEF, 1'b0);
        add_number(nta_pkg::CMD_HEX32, 32'h0123_4567, 1'b0);
        // decimal: zero, one digit, digit count boundaries, largest value
        add_number(nta_pkg::CMD_DEC, 32'd0, 1'b0);
        add_number(nta_pkg::CMD_DEC, 32'd1, 1'b0);
        add_number(nta_pkg::CMD_DEC, 32'd9, 1'b0);
        add_number(nta_pkg::CMD_DEC, 32'd10, 1'b0);
        add_number(nta_pkg::CMD_DEC, 32'd99, 1'b0);
        add_number(nta_pkg::CMD_DEC, 32'd100, 1'b1);
        add_number(nta_pkg::CMD_DEC, 32'd999_999_999, 1'b0);
        add_number(nta_pkg::CMD_DEC, 32'd1_000_000_000, 1'b0);
        add_number(nta_pkg::CMD_DEC, 32'hFFFF_FFFF, 1'b0);
        add_number(nta_pkg::CMD_DEC, 32'd4_294_967_290, 1'b0);
        add_number(nta_pkg::CMD_DEC, 32'h8000_0000, 1'b0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            case ($urandom_range(9))
                5: v = $urandom_range(0, 99);
                6: begin
                    pow10 = 1;
                    repeat ($urandom_range(9)) pow10 = pow10 * 10;
                    v = pow10 - 1 + $urandom_range(2);
                end
                7: v = $urandom >> $urandom_range(31);
                8: v = 32'hFFFF_FFFF - $urandom_range(3);
                9: v = 32'h1 << $urandom_range(31);
                default: v = $urandom;
            endcase
            add_number(nta_pkg::cmd_t'($urandom_range(3)), v, (i % 70) == 35);
        end

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (numbers_to_send.size() != 0 || s_tvalid || chars_due.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatches == 0 && chars_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
